// ----- hdl/tcp_pkg.sv -----
// Shared types and constants for the terrain column projector.
package tcp_pkg;

    localparam int SCREEN_MAX_SIDE = 4096;
    localparam int ROW_W           = 13;
    localparam int COL_W           = 12;
    localparam int DIST_W          = 24;
    localparam int RGBA_W          = 32;
    localparam int ACC_W           = 53;
    localparam int PQ_W            = 19;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [ROW_W-1:0] MAX_ROW = ROW_W'(SCREEN_MAX_SIDE);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SCREEN_HEIGHT = 3'd0,
        REG_CAMERA_ALT    = 3'd1,
        REG_SIN_PITCH     = 3'd2,
        REG_COS_PITCH     = 3'd3,
        REG_INV_TAN       = 3'd4,
        REG_FOG_START     = 3'd5,
        REG_VIEW_DIST     = 3'd6,
        REG_SKY_RGBA      = 3'd7
    } tcp_reg_t;

    // Live configuration, already clamped where needed
    typedef struct packed {
        logic [ROW_W-1:0]         h;
        logic signed [23:0]       alt;
        logic signed [15:0]       sin_p;
        logic signed [15:0]       cos_p;
        logic [23:0]              inv_tan;
        logic [DIST_W-1:0]        fog_start;
        logic [DIST_W-1:0]        view_dist;
        logic [RGBA_W-1:0]        sky;
    } tcp_cfg_t;

    // Classified sample passed from front to back
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic              first;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [RGBA_W-1:0] rgba;
    } tcp_entry_t;

    // One span request
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  top;
        logic [ROW_W-1:0]  bottom;
        logic [RGBA_W-1:0] rgba;
        logic              sky;
        logic              last;
    } tcp_span_t;

endpackage

// ----- hdl/tcp_if.sv -----
// Channel interfaces: sample input, span output and configuration writes.
interface tcp_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] column_x;
    logic        first_sample;
    logic        last_sample;
    logic [23:0] sample_distance;
    logic signed [23:0] terrain_height;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;

    modport source (output valid, column_x, first_sample, last_sample, sample_distance,
                    terrain_height, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, column_x, first_sample, last_sample, sample_distance,
                  terrain_height, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface tcp_span_if;
    logic        valid;
    logic        ready;
    logic [11:0] span_column;
    logic [12:0] span_top;
    logic [12:0] span_bottom;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        sky_span;
    logic        last_of_run;

    modport source (output valid, span_column, span_top, span_bottom, red_out, green_out,
                    blue_out, alpha_out, sky_span, last_of_run, input ready);
    modport sink (input valid, span_column, span_top, span_bottom, red_out, green_out,
                  blue_out, alpha_out, sky_span, last_of_run, output ready);
endinterface

interface tcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/terrain_column_projector.sv -----
// Terrain column projector top level: configuration registers, front, queue, back.
// The front end projects with a 19-step divide, skipped when the projection saturates
// early, and adds a 16-step fog divide when fog applies and does not saturate; both run
// on the shared 1-bit-per-cycle divider. A new sample is taken only once the last one
// has been pushed to the queue.
// The back end emits up to two span requests per sample, one per cycle unless span_ch stalls.
// Reset: asynchronous, active low; clears control state and loads register defaults.
module terrain_column_projector
    import tcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcp_sample_if.sink  sample_ch,
    tcp_span_if.source  span_ch,
    tcp_cfg_if.sink     cfg_ch
);

    logic [12:0]        screen_height_reg;
    logic signed [23:0] camera_alt_reg;
    logic signed [15:0] sin_pitch_reg;
    logic signed [15:0] cos_pitch_reg;
    logic [23:0]        inv_tan_reg;
    logic [23:0]        fog_start_reg;
    logic [23:0]        view_dist_reg;
    logic [31:0]        sky_rgba_reg;

    tcp_cfg_t   cfg;
    logic       fq_valid, fq_ready, bq_valid, bq_ready;
    tcp_entry_t fq_data, bq_data;
    tcp_reg_t   cfg_sel;

    assign cfg_ch.ready = 1'b1;
    assign cfg_sel      = tcp_reg_t'(cfg_ch.index);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= 13'd240;
            camera_alt_reg    <= '0;
            sin_pitch_reg     <= '0;
            cos_pitch_reg     <= 16'sd32767;
            inv_tan_reg       <= 24'd65536;
            fog_start_reg     <= 24'hFFFFFF;
            view_dist_reg     <= 24'hFFFFFF;
            sky_rgba_reg      <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_sel)
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_ch.data[12:0];
                REG_CAMERA_ALT:    camera_alt_reg    <= cfg_ch.data[23:0];
                REG_SIN_PITCH:     sin_pitch_reg     <= cfg_ch.data[15:0];
                REG_COS_PITCH:     cos_pitch_reg     <= cfg_ch.data[15:0];
                REG_INV_TAN:       inv_tan_reg       <= cfg_ch.data[23:0];
                REG_FOG_START:     fog_start_reg     <= cfg_ch.data[23:0];
                REG_VIEW_DIST:     view_dist_reg     <= cfg_ch.data[23:0];
                REG_SKY_RGBA:      sky_rgba_reg      <= cfg_ch.data;
                default:           sky_rgba_reg      <= sky_rgba_reg;
            endcase
        end
    end

    // Screen height saturates to the largest supported side
    assign cfg = '{h: (screen_height_reg > MAX_ROW) ? MAX_ROW : screen_height_reg,
                   alt: camera_alt_reg, sin_p: sin_pitch_reg, cos_p: cos_pitch_reg,
                   inv_tan: inv_tan_reg, fog_start: fog_start_reg,
                   view_dist: view_dist_reg, sky: sky_rgba_reg};

    tcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample_ch (sample_ch),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    tcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    tcp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (bq_valid),
        .q_ready (bq_ready),
        .q_data  (bq_data),
        .span_ch (span_ch)
    );

endmodule

// ----- hdl/tcp_front.sv -----
// Front end: projects one sample to a screen row and applies fog.
module tcp_front
    import tcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  tcp_cfg_t     cfg,
    tcp_sample_if.sink   sample_ch,
    output logic         q_valid,
    input  logic         q_ready,
    output tcp_entry_t   q_data
);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_MUL_A   = 15'b000000000000010,
        ST_MUL_B   = 15'b000000000000100,
        ST_ROT     = 15'b000000000001000,
        ST_MUL_P0  = 15'b000000000010000,
        ST_MUL_P1  = 15'b000000000100000,
        ST_PREP_P  = 15'b000000001000000,
        ST_DIV     = 15'b000000010000000,
        ST_PDONE   = 15'b000000100000000,
        ST_MUL_ROW = 15'b000001000000000,
        ST_ROW     = 15'b000010000000000,
        ST_FOG     = 15'b000100000000000,
        ST_FDONE   = 15'b001000000000000,
        ST_BLEND   = 15'b010000000000000,
        ST_PUSH    = 15'b100000000000000
    } front_state_t;

    front_state_t state_reg, state_next;

    // Captured sample
    logic [COL_W-1:0]    col_reg, col_next;
    logic                first_reg, first_next;
    logic                last_reg, last_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic signed [23:0]  hgt_reg, hgt_next;
    logic [RGBA_W-1:0]   rgba_reg, rgba_next;

    // Datapath
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [27:0]      rot_reg, rot_next;
    logic                    neg_reg, neg_next;
    logic signed [19:0]      pf_reg, pf_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [16:0]             f_reg, f_next;

    // Shared restoring divider
    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [PQ_W-1:0]   low_reg, low_next;
    logic [PQ_W-1:0]   quo_reg, quo_next;
    logic [DIST_W-1:0] dvs_reg, dvs_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              fog_div_reg, fog_div_next;

    // Combinational helpers
    logic signed [24:0]      dy;
    logic signed [40:0]      prod_a, prod_b, prod_lo, prod_hi;
    logic signed [33:0]      prod_row;
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        rot_q;
    logic [ACC_W-1:0]        numr;
    logic [ACC_W-1:0]        hi_part;
    logic [DIST_W:0]         div_t;
    logic                    div_ge;
    logic [PQ_W-1:0]         p_sat;
    logic [ACC_W-1:0]        row_q;
    logic [DIST_W-1:0]       fog_n, fog_d;
    logic [24:0]             blend_v [4];
    logic [16:0]             f_inv;

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign q_valid         = (state_reg == ST_PUSH);
    assign q_data          = '{col: col_reg, first: first_reg, last: last_reg,
                               row: row_reg, rgba: rgba_reg};

    // Arithmetic terms
    always_comb
    begin
        dy       = 25'(hgt_reg) - 25'(cfg.alt);
        prod_a   = dy * cfg.cos_p;
        prod_b   = $signed({1'b0, dist_reg}) * cfg.sin_p;
        prod_lo  = rot_reg * $signed({1'b0, cfg.inv_tan[11:0]});
        prod_hi  = rot_reg * $signed({1'b0, cfg.inv_tan[23:12]});
        prod_row = $signed({1'b0, cfg.h}) * pf_reg;
        mag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rot_q    = (mag + ACC_W'(16384)) >> 15;
        numr     = mag + ACC_W'(dist_reg >> 1);
        hi_part  = numr >> PQ_W;
        div_t    = {rem_reg, low_reg[PQ_W-1]};
        div_ge   = (div_t >= {1'b0, dvs_reg});
        p_sat    = (quo_reg > PQ_W'(262144)) ? PQ_W'(262144) : quo_reg;
        row_q    = ACC_W'(acc_reg + ACC_W'(65536)) >> 17;
        fog_n    = dist_reg - cfg.fog_start;
        fog_d    = cfg.view_dist - cfg.fog_start;
        f_inv    = 17'(65536) - f_reg;
        for (int i = 0; i < 4; i++)
        begin
            blend_v[i] = 25'(rgba_reg[31-8*i -: 8]) * 25'(f_inv)
                       + 25'(cfg.sky[31-8*i -: 8]) * 25'(f_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        dist_next    = dist_reg;
        hgt_next     = hgt_reg;
        rgba_next    = rgba_reg;
        acc_next     = acc_reg;
        rot_next     = rot_reg;
        neg_next     = neg_reg;
        pf_next      = pf_reg;
        row_next     = row_reg;
        f_next       = f_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        fog_div_next = fog_div_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    col_next   = sample_ch.column_x;
                    first_next = sample_ch.first_sample;
                    last_next  = sample_ch.last_sample;
                    dist_next  = (sample_ch.sample_distance == '0) ? DIST_W'(1)
                                                                   : sample_ch.sample_distance;
                    hgt_next   = sample_ch.terrain_height;
                    rgba_next  = {sample_ch.red_in, sample_ch.green_in,
                                  sample_ch.blue_in, sample_ch.alpha_in};
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                acc_next   = ACC_W'(prod_a);
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                acc_next   = acc_reg - ACC_W'(prod_b);
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                rot_next   = acc_reg[ACC_W-1] ? -28'(rot_q) : 28'(rot_q);
                state_next = ST_MUL_P0;
            end
            ST_MUL_P0:
            begin
                acc_next   = ACC_W'(prod_lo);
                state_next = ST_MUL_P1;
            end
            ST_MUL_P1:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_hi) <<< 12);
                state_next = ST_PREP_P;
            end
            ST_PREP_P:
            begin
                neg_next = acc_reg[ACC_W-1];
                if (hi_part >= ACC_W'(dist_reg))
                begin
                    // quotient is far past the clamp
                    quo_next   = PQ_W'(262144);
                    state_next = ST_PDONE;
                end
                else
                begin
                    rem_next     = hi_part[DIST_W-1:0];
                    low_next     = numr[PQ_W-1:0];
                    quo_next     = '0;
                    dvs_next     = dist_reg;
                    cnt_next     = 5'(PQ_W);
                    fog_div_next = 1'b0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? DIST_W'(div_t - {1'b0, dvs_reg}) : div_t[DIST_W-1:0];
                low_next = {low_reg[PQ_W-2:0], 1'b0};
                quo_next = {quo_reg[PQ_W-2:0], div_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = fog_div_reg ? ST_FDONE : ST_PDONE;
                end
            end
            ST_PDONE:
            begin
                pf_next    = neg_reg ? 20'sd65536 + $signed({1'b0, p_sat})
                                     : 20'sd65536 - $signed({1'b0, p_sat});
                state_next = ST_MUL_ROW;
            end
            ST_MUL_ROW:
            begin
                acc_next   = ACC_W'(prod_row);
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    row_next = '0;
                end
                else if (row_q > ACC_W'(cfg.h))
                begin
                    row_next = cfg.h;
                end
                else
                begin
                    row_next = row_q[ROW_W-1:0];
                end
                state_next = ST_FOG;
            end
            ST_FOG:
            begin
                if (dist_reg > cfg.fog_start)
                begin
                    if (cfg.view_dist <= cfg.fog_start || fog_n >= fog_d)
                    begin
                        f_next     = 17'(65536);
                        state_next = ST_BLEND;
                    end
                    else
                    begin
                        rem_next     = fog_n;
                        low_next     = '0;
                        quo_next     = '0;
                        dvs_next     = fog_d;
                        cnt_next     = 5'd16;
                        fog_div_next = 1'b1;
                        state_next   = ST_DIV;
                    end
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_FDONE:
            begin
                f_next     = {1'b0, quo_reg[15:0]};
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rgba_next[31-8*i -: 8] = blend_v[i][23:16];
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        dist_reg    <= dist_next;
        hgt_reg     <= hgt_next;
        rgba_reg    <= rgba_next;
        acc_reg     <= acc_next;
        rot_reg     <= rot_next;
        neg_reg     <= neg_next;
        pf_reg      <= pf_next;
        row_reg     <= row_next;
        f_reg       <= f_next;
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        cnt_reg     <= cnt_next;
        fog_div_reg <= fog_div_next;
    end

endmodule

// ----- hdl/tcp_queue.sv -----
// Small register queue between front and back.
module tcp_queue
    import tcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tcp_entry_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output tcp_entry_t out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    tcp_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- hdl/tcp_back.sv -----
// Back end: occlusion tracking and span emission.
module tcp_back
    import tcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tcp_cfg_t    cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  tcp_entry_t  q_data,
    tcp_span_if.source  span_ch
);

    logic [ROW_W-1:0] occ_reg, occ_next;
    logic             fin_reg, fin_next;
    logic             out_valid_reg, out_valid_next;
    tcp_span_t        out_reg, out_next;
    logic             pend_valid_reg, pend_valid_next;
    tcp_span_t        pend_reg, pend_next;

    logic             out_free, take, live, hit, sky_hit;
    logic [ROW_W-1:0] occ_eff, occ_new;
    tcp_span_t        terrain_span, sky_span_req;

    assign out_free = !out_valid_reg || span_ch.ready;
    assign q_ready  = out_free && !pend_valid_reg;
    assign take     = q_valid && q_ready;

    // Classify the entry against the occlusion state
    always_comb
    begin
        live    = q_data.first || !fin_reg;
        occ_eff = q_data.first ? cfg.h : occ_reg;
        hit     = live && (q_data.row < occ_eff);
        sky_hit = live && (q_data.row != '0) && q_data.last;
        occ_new = hit ? q_data.row : occ_eff;

        terrain_span = '{col: q_data.col, top: q_data.row, bottom: occ_eff,
                         rgba: q_data.rgba, sky: 1'b0, last: !sky_hit};
        sky_span_req = '{col: q_data.col, top: '0, bottom: occ_new,
                         rgba: cfg.sky, sky: 1'b1, last: 1'b1};
    end

    // Output and pending slot
    always_comb
    begin
        occ_next        = occ_reg;
        fin_next        = fin_reg;
        out_next        = out_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !span_ch.ready;
        pend_valid_next = pend_valid_reg;

        if (pend_valid_reg && out_free)
        begin
            out_next        = pend_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (take)
        begin
            if (hit)
            begin
                out_next        = terrain_span;
                out_valid_next  = 1'b1;
                pend_next       = sky_span_req;
                pend_valid_next = sky_hit;
            end
            else if (sky_hit)
            begin
                out_next       = sky_span_req;
                out_valid_next = 1'b1;
            end
            if (live)
            begin
                occ_next = occ_new;
                fin_next = (q_data.row == '0) || q_data.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg        <= occ_next;
            fin_reg        <= fin_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    // Port drive
    assign span_ch.valid       = out_valid_reg;
    assign span_ch.span_column = out_reg.col;
    assign span_ch.span_top    = out_reg.top;
    assign span_ch.span_bottom = out_reg.bottom;
    assign span_ch.red_out     = out_reg.rgba[31:24];
    assign span_ch.green_out   = out_reg.rgba[23:16];
    assign span_ch.blue_out    = out_reg.rgba[15:8];
    assign span_ch.alpha_out   = out_reg.rgba[7:0];
    assign span_ch.sky_span    = out_reg.sky;
    assign span_ch.last_of_run = out_reg.last;

endmodule
